/* hdl/etbs_pkg.sv */
`default_nettype none

package etbs_pkg;

    // Store geometry: eight byte lanes, one bank per lane.
    localparam int LANES  = 8;
    localparam int BYTE_W = 8;

    // Field codes.
    localparam logic       MODE_READ   = 1'b0;
    localparam logic       MODE_WRITE  = 1'b1;
    localparam logic [1:0] SIZE_1      = 2'd0;
    localparam logic [1:0] SIZE_2      = 2'd1;
    localparam logic [1:0] SIZE_4      = 2'd2;
    localparam logic [1:0] SIZE_8      = 2'd3;
    localparam logic       STATUS_OK   = 1'b0;
    localparam logic       STATUS_OOR  = 1'b1;
    localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;

    typedef logic [BYTE_W-1:0]            t_byte;
    typedef logic [LANES-1:0][BYTE_W-1:0] t_lane_bytes;

    // One input item.
    typedef struct packed {
        logic        mode;
        logic [1:0]  size_code;
        logic        big_endian;
        logic        signed_read;
        logic [15:0] byte_offset;
        logic [63:0] write_value;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [63:0] read_data;
        logic [16:0] next_offset;
        logic        status;
    } t_out_item;

    // Control carried alongside an accepted access in the stage-one register.
    typedef struct packed {
        logic        is_write;
        logic        oor;
        logic [2:0]  ofs_lo;
        logic [1:0]  size_code;
        logic        big_endian;
        logic        signed_read;
        logic [16:0] next_offset;
    } t_s1_ctl;

    // Number of bytes for a size code.
    function automatic logic [3:0] size_bytes(input logic [1:0] code);
        logic [3:0] n;
        begin
            unique case (code)
                SIZE_1:  n = 4'd1;
                SIZE_2:  n = 4'd2;
                SIZE_4:  n = 4'd4;
                SIZE_8:  n = 4'd8;
                default: n = 4'd1;
            endcase
            return n;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/etbs_lane_mem.sv */
`default_nettype none

module etbs_lane_mem
    import etbs_pkg::*;
#(
    parameter int ROWS = 512,
    parameter int RW   = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_re,
    input  wire logic [LANES-1:0] i_we,
    input  wire logic [RW-1:0]    i_addr [LANES],
    input  wire t_lane_bytes      i_wdata,
    output t_lane_bytes           o_rdata
);

    // Each lane is its own single-port bank with a registered read.
    t_byte r_mem [LANES][ROWS];

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < LANES; b++) begin
            if (i_we[b]) begin
                r_mem[b][i_addr[b]] <= i_wdata[b];
            end
            if (i_re) begin
                o_rdata[b] <= r_mem[b][i_addr[b]];
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/endian_typed_byte_store_access.sv */
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in      | input     | i_in_valid/o_in_stall | i_in_item  (t_in_item)
// out     | output    | o_out_valid/i_out_stall | o_out_item (t_out_item)
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (buffer length)
//
// The banked memory is read at the edge that accepts an item; the assembled
// result enters the output register from stage one once the output is free.
// A new item can be accepted every cycle while no clear runs and the output is not
// stalled, set by the single access port of each byte-lane bank.
// After reset the store is cleared one row of eight bytes per cycle, through
// every row, with o_in_stall held high.
// A stalled output holds the result and back-pressures the input side.

module endian_typed_byte_store_access
    import etbs_pkg::*;
#(
    parameter int STORE_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [12:0] i_cfg_data
);

    localparam int ROWS = (STORE_BYTES + LANES - 1) / LANES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [16:0]   STORE_LIM = 17'(STORE_BYTES);

    logic [12:0]   r_len;
    logic          r_clearing;
    logic [RW-1:0] r_clr_row;
    logic          r_s1_valid;
    t_s1_ctl       r_s1;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          out_free;
    logic          s1_free;
    logic          in_acc;
    t_s1_ctl       n_s1;
    t_out_item     n_out;
    logic [3:0]    in_size;
    logic [16:0]   used_len;
    logic [16:0]   end_pos;
    logic [RW-1:0] row_lo;
    logic [RW-1:0] row_hi;
    logic          mem_re;
    logic [LANES-1:0] mem_we;
    logic [RW-1:0] mem_addr [LANES];
    t_lane_bytes   mem_wdata;
    t_lane_bytes   mem_rdata;

    // Configuration is always taken.
    assign o_cfg_ready = 1'b1;

    // Pipeline flow control.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = r_clearing || !s1_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Range check and row selection for the incoming item.
    always_comb begin
        in_size  = size_bytes(i_in_item.size_code);
        used_len = ({4'd0, r_len} > STORE_LIM) ? STORE_LIM : {4'd0, r_len};
        end_pos  = {1'b0, i_in_item.byte_offset} + 17'(in_size);
        row_lo   = RW'(i_in_item.byte_offset >> 3);
        row_hi   = row_lo + RW'(1);

        n_s1.is_write    = (i_in_item.mode == MODE_WRITE);
        n_s1.oor         = (end_pos > used_len);
        n_s1.ofs_lo      = i_in_item.byte_offset[2:0];
        n_s1.size_code   = i_in_item.size_code;
        n_s1.big_endian  = i_in_item.big_endian;
        n_s1.signed_read = i_in_item.signed_read;
        n_s1.next_offset = (n_s1.is_write && !n_s1.oor) ? end_pos
                                                          : {1'b0, i_in_item.byte_offset};
    end

    // Per-lane memory commands: clearing sweep, or the accepted access.
    always_comb begin
        logic [2:0] pos;
        logic [2:0] lane;
        mem_re = in_acc && !n_s1.is_write;
        for (int b = 0; b < LANES; b++) begin
            pos  = 3'(b) - n_s1.ofs_lo;
            lane = n_s1.big_endian ? (3'(in_size - 4'd1) - pos) : pos;
            if (r_clearing) begin
                mem_addr[b]  = r_clr_row;
                mem_we[b]    = 1'b1;
                mem_wdata[b] = '0;
            end else begin
                mem_addr[b]  = (3'(b) >= n_s1.ofs_lo) ? row_lo : row_hi;
                mem_we[b]    = in_acc && n_s1.is_write && !n_s1.oor
                               && ({1'b0, pos} < in_size);
                mem_wdata[b] = i_in_item.write_value[lane*BYTE_W +: BYTE_W];
            end
        end
    end

    etbs_lane_mem #(
        .ROWS (ROWS),
        .RW   (RW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (mem_re),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Byte assembly, endian order and sign extension of the read data.
    always_comb begin
        logic [3:0]  sz;
        logic [2:0]  pos;
        logic [2:0]  bank;
        logic        sign_bit;
        t_lane_bytes val;
        sz = size_bytes(r_s1.size_code);
        for (int l = 0; l < LANES; l++) begin
            pos  = r_s1.big_endian ? (3'(sz - 4'd1) - 3'(l)) : 3'(l);
            bank = r_s1.ofs_lo + pos;
            val[l] = (4'(l) < sz) ? mem_rdata[bank] : '0;
        end
        sign_bit = val[3'(sz - 4'd1)][BYTE_W-1];
        for (int l = 0; l < LANES; l++) begin
            if ((4'(l) >= sz) && r_s1.signed_read && sign_bit) begin
                val[l] = BYTE_ONES;
            end
        end
        n_out.read_data   = (r_s1.is_write || r_s1.oor) ? 64'd0 : val;
        n_out.next_offset = r_s1.next_offset;
        n_out.status      = r_s1.oor ? STATUS_OOR : STATUS_OK;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_clearing  <= 1'b1;
            r_clr_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_len <= i_cfg_data;
            end
            if (r_clearing) begin
                r_clr_row <= r_clr_row + RW'(1);
                if (r_clr_row == LAST_ROW) begin
                    r_clearing <= 1'b0;
                end
            end
            if (s1_free) begin
                r_s1_valid <= in_acc;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (out_free && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
